>>> rtl/tone_and_scale_sequencer_assert.svh
// Assertion macros for the tone and scale sequencer.
// Included by the modules that carry assertions; depends on nothing else.
`ifndef TONE_AND_SCALE_SEQUENCER_ASSERT_SVH
`define TONE_AND_SCALE_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define TSS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tss_pkg.sv
// Types, codes and constants shared by the tone and scale sequencer modules.
// No dependencies.
package tss_pkg;

   localparam int NOTE_SLOTS_DEF = 16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_RESOLUTION = 0;
   localparam logic [4:0] RES_RESET = 5'd8;
   localparam logic [4:0] RES_MAX = 5'd20;

   localparam logic [13:0] DUTY_FULL = 14'd10000;
   // floor(x / 625) == (x * DUTY_RECIP) >> 40 for any x below 2^30
   localparam logic [30:0] DUTY_RECIP = 31'd1759218605;

   typedef enum logic [2:0] {
      KIND_TICK       = 3'd0,
      KIND_DUTY_TONE  = 3'd1,
      KIND_FIXED_TONE = 3'd2,
      KIND_LOAD_NOTE  = 3'd3,
      KIND_SCALE      = 3'd4,
      KIND_STOP       = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BUSY      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_TONE_END  = 3'd3,
      ST_SCALE_END = 3'd4,
      ST_NEXT_NOTE = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      PLAY_IDLE  = 2'd0,
      PLAY_TONE  = 2'd1,
      PLAY_SCALE = 2'd2
   } play_type;

   typedef enum logic [1:0] {
      PWM_OFF  = 2'd0,
      PWM_DUTY = 2'd1,
      PWM_HALF = 2'd2
   } pwm_type;

   typedef enum logic [2:0] {
      ACT_KEEP,
      ACT_SILENT,
      ACT_TONE_DUTY,
      ACT_TONE_HALF,
      ACT_NOTE
   } out_act_type;

   typedef struct packed {
      out_act_type act;
      logic [15:0] freq;
      logic [29:0] duty_x;
      logic        playing;
      status_type  status;
   } stage_type;

endpackage

>>> rtl/tss_note_mem.sv
// Note table: synchronous single-write, single-read memory, registered read.
// No package dependencies.
module tss_note_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [15:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]       rd_data
);

   logic [15:0] mem_ff [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tss_seq_ctrl.sv
// Sequencer control: play state, tick timing, scale stepping, table access.
// Depends on tss_pkg and the assertion macro header.
`include "tone_and_scale_sequencer_assert.svh"
module tss_seq_ctrl #(
   parameter int NOTE_SLOTS = tss_pkg::NOTE_SLOTS_DEF,
   parameter int POS_W      = 4,
   parameter int CNT_W      = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [2:0]          kind,
   input  logic [15:0]         frequency,
   input  logic [13:0]         duty_hundredths,
   input  logic [31:0]         duration,
   input  logic [3:0]          note_slot,
   input  logic [4:0]          note_count,
   input  logic                direction_up,
   input  logic [4:0]          res_bits,
   output tss_pkg::stage_type  stage,
   output logic                mem_wr_en,
   output logic [POS_W-1:0]    mem_wr_addr,
   output logic [POS_W-1:0]    mem_rd_addr
);
   import tss_pkg::*;

   play_type         play_mode_ff, play_mode_in;
   logic [31:0]      elapsed_ff, elapsed_in;
   logic [31:0]      tone_ticks_ff, tone_ticks_in;
   logic [31:0]      note_ticks_ff, note_ticks_in;
   logic [CNT_W-1:0] notes_ff, notes_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             asc_ff, asc_in;

   logic [31:0]      el_inc;
   logic [CNT_W-1:0] cnt_sat;
   logic [13:0]      h_sat;
   logic [4:0]       bits;
   logic [33:0]      duty_p;

   always_comb begin
      el_inc  = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 32'd1;
      cnt_sat = (32'(note_count) > 32'(NOTE_SLOTS)) ? CNT_W'(NOTE_SLOTS)
                                                    : CNT_W'(note_count);
      h_sat   = (duty_hundredths > DUTY_FULL) ? DUTY_FULL : duty_hundredths;
      bits    = (res_bits > RES_MAX) ? RES_MAX : res_bits;
      duty_p  = (34'(h_sat) << bits) - 34'(h_sat);
   end

   always_comb begin
      play_mode_in  = play_mode_ff;
      elapsed_in    = elapsed_ff;
      tone_ticks_in = tone_ticks_ff;
      note_ticks_in = note_ticks_ff;
      notes_in      = notes_ff;
      pos_in        = pos_ff;
      asc_in        = asc_ff;
      mem_wr_en     = 1'b0;
      stage.act     = ACT_KEEP;
      stage.status  = ST_OK;
      if (accept) begin
         unique case (kind_type'(kind)) inside
            KIND_TICK: begin
               if (play_mode_ff != PLAY_IDLE) begin
                  elapsed_in = el_inc;
                  if (play_mode_ff == PLAY_TONE) begin
                     if (el_inc >= tone_ticks_ff) begin
                        play_mode_in = PLAY_IDLE;
                        stage.act    = ACT_SILENT;
                        stage.status = ST_TONE_END;
                     end
                  end else if (el_inc >= note_ticks_ff) begin
                     if (asc_ff ? (32'(pos_ff) + 32'd1 >= 32'(notes_ff))
                                : (pos_ff == '0)) begin
                        play_mode_in = PLAY_IDLE;
                        stage.act    = ACT_SILENT;
                        stage.status = ST_SCALE_END;
                     end else begin
                        pos_in       = asc_ff ? pos_ff + 1'b1 : pos_ff - 1'b1;
                        elapsed_in   = '0;
                        stage.act    = ACT_NOTE;
                        stage.status = ST_NEXT_NOTE;
                     end
                  end
               end
            end
            KIND_DUTY_TONE, KIND_FIXED_TONE: begin
               if (play_mode_ff != PLAY_IDLE) begin
                  stage.status = ST_BUSY;
               end else begin
                  play_mode_in  = PLAY_TONE;
                  elapsed_in    = '0;
                  tone_ticks_in = duration;
                  stage.act     = (kind_type'(kind) == KIND_DUTY_TONE) ? ACT_TONE_DUTY
                                                                       : ACT_TONE_HALF;
               end
            end
            KIND_LOAD_NOTE: begin
               mem_wr_en = (32'(note_slot) < 32'(NOTE_SLOTS));
            end
            KIND_SCALE: begin
               if (play_mode_ff != PLAY_IDLE) begin
                  stage.status = ST_BUSY;
               end else if (cnt_sat == '0) begin
                  stage.status = ST_EMPTY;
               end else begin
                  play_mode_in  = PLAY_SCALE;
                  notes_in      = cnt_sat;
                  note_ticks_in = duration;
                  asc_in        = direction_up;
                  pos_in        = direction_up ? '0 : POS_W'(32'(cnt_sat) - 32'd1);
                  elapsed_in    = '0;
                  stage.act     = ACT_NOTE;
               end
            end
            KIND_STOP: begin
               play_mode_in = PLAY_IDLE;
               stage.act    = ACT_SILENT;
            end
            default: begin
            end
         endcase
      end
      stage.freq    = frequency;
      stage.duty_x  = duty_p[33:4];
      stage.playing = (play_mode_in != PLAY_IDLE);
      mem_wr_addr   = POS_W'(note_slot);
      mem_rd_addr   = pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         play_mode_ff  <= PLAY_IDLE;
         elapsed_ff    <= '0;
         tone_ticks_ff <= '0;
         note_ticks_ff <= '0;
         notes_ff      <= '0;
         pos_ff        <= '0;
         asc_ff        <= 1'b1;
      end else begin
         play_mode_ff  <= play_mode_in;
         elapsed_ff    <= elapsed_in;
         tone_ticks_ff <= tone_ticks_in;
         note_ticks_ff <= note_ticks_in;
         notes_ff      <= notes_in;
         pos_ff        <= pos_in;
         asc_ff        <= asc_in;
      end
   end

   `TSS_ASSERT_SAME(a_pos_in_scale, clock, reset, play_mode_ff == PLAY_SCALE,
                    32'(pos_ff) < 32'(notes_ff), "note position past note count")

endmodule

>>> rtl/tss_out_stage.sv
// Output stage: applies the sounding state change, finishes the duty divide,
// holds the result word. Depends on tss_pkg and the assertion macro header.
`include "tone_and_scale_sequencer_assert.svh"
module tss_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic               take,
   input  tss_pkg::stage_type stage,
   input  logic [15:0]        note_freq,
   output logic               rsp_valid,
   output logic [15:0]        rsp_current_frequency,
   output logic [1:0]         rsp_pwm_mode,
   output logic [19:0]        rsp_duty_value,
   output logic               rsp_playing,
   output logic [2:0]         rsp_status
);
   import tss_pkg::*;

   logic        valid_ff, valid_in;
   logic [15:0] freq_ff, freq_in;
   pwm_type     mode_ff, mode_in;
   logic [19:0] duty_ff, duty_in;
   logic        playing_ff;
   status_type  status_ff;
   logic [60:0] duty_prod;

   assign duty_prod = {31'b0, stage.duty_x} * {30'b0, DUTY_RECIP};

   always_comb begin
      freq_in  = freq_ff;
      mode_in  = mode_ff;
      duty_in  = duty_ff;
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         case (stage.act)
            ACT_SILENT: begin
               freq_in = '0;
               mode_in = PWM_OFF;
               duty_in = '0;
            end
            ACT_TONE_DUTY: begin
               freq_in = stage.freq;
               mode_in = PWM_DUTY;
               duty_in = duty_prod[59:40];
            end
            ACT_TONE_HALF: begin
               freq_in = stage.freq;
               mode_in = PWM_HALF;
               duty_in = '0;
            end
            ACT_NOTE: begin
               freq_in = note_freq;
               mode_in = PWM_HALF;
               duty_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         freq_ff  <= '0;
         mode_ff  <= PWM_OFF;
         duty_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         freq_ff  <= freq_in;
         mode_ff  <= mode_in;
         duty_ff  <= duty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         playing_ff <= stage.playing;
         status_ff  <= stage.status;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_current_frequency = freq_ff;
   assign rsp_pwm_mode          = mode_ff;
   assign rsp_duty_value        = duty_ff;
   assign rsp_playing           = playing_ff;
   assign rsp_status            = status_ff;

   `TSS_ASSERT_SAME(a_silent_when_idle, clock, reset, valid_ff && !playing_ff,
                    mode_ff == PWM_OFF && freq_ff == '0, "sound while not playing")
   `TSS_ASSERT_SAME(a_duty_only_in_duty_mode, clock, reset, duty_ff != '0,
                    mode_ff == PWM_DUTY, "duty count outside explicit duty mode")
   `TSS_ASSERT_SAME(a_busy_means_playing, clock, reset,
                    valid_ff && status_ff == ST_BUSY, playing_ff,
                    "busy reject while idle")

endmodule

>>> rtl/tone_and_scale_sequencer.sv
// Top level of the buzzer tone and scale sequencer: CSR port, pipeline
// handshake, note table, control and output stage. Depends on tss_pkg.
//
//   channel  direction  handshake             contents
//   req      in         req_valid/req_stall   kind, frequency, duty, duration, slot, count, dir
//   rsp      out        rsp_valid/rsp_stall   frequency, pwm mode, duty, playing, status
//   csr      in/out     APB, pready high      resolution_bits at byte address 0
//
// One word accepted per cycle, sustained, while rsp_stall is low. Each word passes the note
// table read in the table-read stage, then the result register, before its result appears.
// Reset clears all control state; the note table is not cleared and needs no pass.
// A stalled result holds the output register; one more word can be taken into the
// table-read stage, after which req_stall rises until the result is taken.
`include "tone_and_scale_sequencer_assert.svh"
module tone_and_scale_sequencer #(
   parameter int NOTE_SLOTS = tss_pkg::NOTE_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [2:0]                     req_kind,
   input  logic [15:0]                    req_frequency,
   input  logic [13:0]                    req_duty_hundredths,
   input  logic [31:0]                    req_duration,
   input  logic [3:0]                     req_note_slot,
   input  logic [4:0]                     req_note_count,
   input  logic                           req_direction_up,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [15:0]                    rsp_current_frequency,
   output logic [1:0]                     rsp_pwm_mode,
   output logic [19:0]                    rsp_duty_value,
   output logic                           rsp_playing,
   output logic [2:0]                     rsp_status,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tss_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tss_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tss_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import tss_pkg::*;

   localparam int POS_W = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
   localparam int CNT_W = $clog2(NOTE_SLOTS + 1);
   localparam logic [CSR_ADDR_W-1:0] RES_ADDR = CSR_ADDR_W'(CSR_RESOLUTION * 4);

   logic        res_sel;
   logic [4:0]  res_ff, res_in;

   logic        s1_valid_ff, s1_valid_in;
   stage_type   s1_ff;
   stage_type   stage;
   logic        accept, s1_move, rsp_take;

   logic             mem_wr_en;
   logic [POS_W-1:0] mem_wr_addr, mem_rd_addr;
   logic [15:0]      note_freq;

   assign res_sel    = (csr_paddr == RES_ADDR);
   assign csr_pready = 1'b1;
   assign csr_prdata = res_sel ? CSR_DATA_W'(res_ff) : '0;
   assign res_in     = (csr_psel && csr_penable && csr_pwrite && res_sel)
                       ? csr_pwdata[4:0] : res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= RES_RESET;
      end else begin
         res_ff <= res_in;
      end
   end

   assign rsp_take    = rsp_valid && !rsp_stall;
   assign s1_move     = s1_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall   = s1_valid_ff && !s1_move;
   assign accept      = req_valid && !req_stall;
   assign s1_valid_in = accept || (s1_valid_ff && !s1_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= stage;
      end
   end

   tss_seq_ctrl #(
      .NOTE_SLOTS (NOTE_SLOTS),
      .POS_W      (POS_W),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .kind            (req_kind),
      .frequency       (req_frequency),
      .duty_hundredths (req_duty_hundredths),
      .duration        (req_duration),
      .note_slot       (req_note_slot),
      .note_count      (req_note_count),
      .direction_up    (req_direction_up),
      .res_bits        (res_ff),
      .stage           (stage),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_rd_addr     (mem_rd_addr)
   );

   tss_note_mem #(
      .DEPTH  (NOTE_SLOTS),
      .ADDR_W (POS_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_frequency),
      .rd_en   (accept),
      .rd_addr (mem_rd_addr),
      .rd_data (note_freq)
   );

   tss_out_stage u_out (
      .clock                 (clock),
      .reset                 (reset),
      .load                  (s1_move),
      .take                  (rsp_take),
      .stage                 (s1_ff),
      .note_freq             (note_freq),
      .rsp_valid             (rsp_valid),
      .rsp_current_frequency (rsp_current_frequency),
      .rsp_pwm_mode          (rsp_pwm_mode),
      .rsp_duty_value        (rsp_duty_value),
      .rsp_playing           (rsp_playing),
      .rsp_status            (rsp_status)
   );

   `TSS_ASSERT_NEXT(a_accept_fills_stage, clock, reset, accept, s1_valid_ff,
                    "accepted word lost before table-read stage")

endmodule

>>> dv/tone_and_scale_sequencer_test.sv
// Self-checking testbench for tone_and_scale_sequencer: random and directed words, with
// the outputs checked against a state predictor kept in a small scoreboard class.
// Depends on tss_pkg and the tone_and_scale_sequencer RTL.
module tone_and_scale_sequencer_test;
   import tss_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int RANDOM_WORDS = 1400;
   localparam int RESULT_LATENCY = 2;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] freq;
      logic [13:0] hund;
      logic [31:0] dur;
      logic [3:0]  slot;
      logic [4:0]  count;
      logic        up;
   } tone_word_type;

   typedef struct packed {
      logic [15:0] freq;
      logic [1:0]  pwm;
      logic [19:0] duty;
      logic        playing;
      logic [2:0]  status;
   } tone_result_type;

   class sequencer_scoreboard;
      logic [4:0]      res_bits;
      play_type        mode;
      logic [31:0]     elapsed;
      logic [31:0]     tone_len;
      logic [31:0]     note_len;
      logic [15:0]     notes [16];
      logic [4:0]      n_notes;
      logic [4:0]      pos;
      logic            up;
      logic [15:0]     freq;
      logic [19:0]     duty;
      pwm_type         pwm;
      tone_result_type pending_results [$];
      int              errors;

      function new();
         res_bits = RES_RESET;
         mode = PLAY_IDLE;
         elapsed = '0;
         tone_len = '0;
         note_len = '0;
         n_notes = '0;
         pos = '0;
         up = 1'b1;
         freq = '0;
         duty = '0;
         pwm = PWM_OFF;
         errors = 0;
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      function void silence();
         mode = PLAY_IDLE;
         freq = '0;
         duty = '0;
         pwm = PWM_OFF;
      endfunction

      function void sound_note();
         freq = notes[pos[3:0]];
         pwm = PWM_HALF;
         duty = '0;
         elapsed = '0;
      endfunction

      function logic [19:0] duty_for(logic [13:0] hund);
         logic [63:0] top;
         logic [63:0] h;
         top = (64'd1 << ((res_bits > RES_MAX) ? RES_MAX : res_bits)) - 64'd1;
         h = (hund > DUTY_FULL) ? 64'(DUTY_FULL) : 64'(hund);
         return 20'((top * h) / 64'(DUTY_FULL));
      endfunction

      function status_type advance_tick();
         if (mode == PLAY_IDLE)
            return ST_OK;
         if (elapsed != '1)
            elapsed++;
         if (mode == PLAY_TONE) begin
            if (elapsed >= tone_len) begin
               silence();
               return ST_TONE_END;
            end
            return ST_OK;
         end
         if (elapsed < note_len)
            return ST_OK;
         if (up) begin
            if (pos + 5'd1 >= n_notes) begin
               silence();
               return ST_SCALE_END;
            end
            pos++;
         end else begin
            if (pos == '0) begin
               silence();
               return ST_SCALE_END;
            end
            pos--;
         end
         sound_note();
         return ST_NEXT_NOTE;
      endfunction

      function void note_word(tone_word_type w);
         status_type      st;
         logic [4:0]      c;
         tone_result_type r;
         st = ST_OK;
         case (w.kind) inside
            KIND_TICK: st = advance_tick();
            KIND_DUTY_TONE, KIND_FIXED_TONE: begin
               if (mode != PLAY_IDLE) begin
                  st = ST_BUSY;
               end else begin
                  freq = w.freq;
                  if (w.kind == KIND_DUTY_TONE) begin
                     pwm = PWM_DUTY;
                     duty = duty_for(w.hund);
                  end else begin
                     pwm = PWM_HALF;
                     duty = '0;
                  end
                  elapsed = '0;
                  tone_len = w.dur;
                  mode = PLAY_TONE;
               end
            end
            KIND_LOAD_NOTE: notes[w.slot] = w.freq;
            KIND_SCALE: begin
               c = (w.count > 5'(NOTE_SLOTS_DEF)) ? 5'(NOTE_SLOTS_DEF) : w.count;
               if (mode != PLAY_IDLE) begin
                  st = ST_BUSY;
               end else if (c == '0) begin
                  st = ST_EMPTY;
               end else begin
                  n_notes = c;
                  note_len = w.dur;
                  up = w.up;
                  pos = w.up ? 5'd0 : c - 5'd1;
                  mode = PLAY_SCALE;
                  sound_note();
               end
            end
            KIND_STOP: silence();
            default: ;
         endcase
         r.freq = freq;
         r.pwm = pwm;
         r.duty = duty;
         r.playing = (mode != PLAY_IDLE);
         r.status = st;
         pending_results.push_back(r);
      endfunction

      task check_result(tone_result_type got);
         tone_result_type want;
         if (pending_results.size() == 0) begin
            report("result word with nothing expected");
            return;
         end
         want = pending_results.pop_front();
         if (got.freq !== want.freq)
            report($sformatf("frequency got %0d want %0d", got.freq, want.freq));
         if (got.pwm !== want.pwm)
            report($sformatf("pwm_mode got %0d want %0d", got.pwm, want.pwm));
         if (got.duty !== want.duty)
            report($sformatf("duty_value got %0d want %0d", got.duty, want.duty));
         if (got.playing !== want.playing)
            report($sformatf("playing got %0d want %0d", got.playing, want.playing));
         if (got.status !== want.status)
            report($sformatf("status got %0d want %0d", got.status, want.status));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [2:0]            req_kind;
   logic [15:0]           req_frequency;
   logic [13:0]           req_duty_hundredths;
   logic [31:0]           req_duration;
   logic [3:0]            req_note_slot;
   logic [4:0]            req_note_count;
   logic                  req_direction_up;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [15:0]           rsp_current_frequency;
   logic [1:0]            rsp_pwm_mode;
   logic [19:0]           rsp_duty_value;
   logic                  rsp_playing;
   logic [2:0]            rsp_status;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sequencer_scoreboard sb;
   bit                  slot_loaded [16];
   int                  hold_cycles = 0;

   tone_and_scale_sequencer u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_kind              (req_kind),
      .req_frequency         (req_frequency),
      .req_duty_hundredths   (req_duty_hundredths),
      .req_duration          (req_duration),
      .req_note_slot         (req_note_slot),
      .req_note_count        (req_note_count),
      .req_direction_up      (req_direction_up),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_current_frequency (rsp_current_frequency),
      .rsp_pwm_mode          (rsp_pwm_mode),
      .rsp_duty_value        (rsp_duty_value),
      .rsp_playing           (rsp_playing),
      .rsp_status            (rsp_status),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_word('{req_kind, req_frequency, req_duty_hundredths, req_duration,
                           req_note_slot, req_note_count, req_direction_up});
         if (rsp_valid && !rsp_stall)
            sb.check_result('{rsp_current_frequency, rsp_pwm_mode, rsp_duty_value,
                              rsp_playing, rsp_status});
      end
   end

   // receiver stall pattern, with a long hold-off on request
   initial begin : rsp_side
      int pattern;
      int left;
      int period;
      pattern = 0;
      left = 0;
      period = 2;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            if (left == 0) begin
               pattern = $urandom_range(0, 3);
               left = $urandom_range(20, 200);
               period = $urandom_range(2, 5);
            end
            left--;
            case (pattern)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (left % period == 0);
            endcase
         end
      end
   end

   function automatic tone_word_type make_word(logic [2:0] kind, logic [15:0] freq,
                                               logic [13:0] hund, logic [31:0] dur,
                                               logic [3:0] slot, logic [4:0] count,
                                               logic up);
      tone_word_type w;
      w = '{kind, freq, hund, dur, slot, count, up};
      if (kind == KIND_LOAD_NOTE)
         slot_loaded[slot] = 1'b1;
      return w;
   endfunction

   function automatic tone_word_type random_word();
      tone_word_type w;
      int            pick;
      int            prefix;
      w.freq = 16'($urandom);
      w.hund = 14'($urandom);
      w.dur = $urandom;
      w.slot = 4'($urandom);
      w.count = 5'($urandom_range(0, 16));
      w.up = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 50) w.kind = KIND_TICK;
      else if (pick < 60) w.kind = KIND_DUTY_TONE;
      else if (pick < 68) w.kind = KIND_FIXED_TONE;
      else if (pick < 80) w.kind = KIND_LOAD_NOTE;
      else if (pick < 96) w.kind = KIND_SCALE;
      else if (pick < 99) w.kind = KIND_STOP;
      else w.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      pick = $urandom_range(0, 99);
      if (pick < 80) w.dur = $urandom_range(0, 4);
      else if (pick < 90) w.dur = $urandom_range(5, 40);
      else if (pick < 93) w.dur = '1;
      if (w.kind == KIND_SCALE) begin
         // only slots already loaded may be played
         prefix = 0;
         while (prefix < 16 && slot_loaded[prefix])
            prefix++;
         if (prefix == 16 && $urandom_range(0, 9) == 0)
            w.count = 5'($urandom_range(17, 31));
         else if ($urandom_range(0, 9) != 0)
            w.count = 5'($urandom_range((prefix == 0) ? 0 : 1, prefix));
         else
            w.count = '0;
      end
      if (w.kind == KIND_LOAD_NOTE)
         slot_loaded[w.slot] = 1'b1;
      return w;
   endfunction

   task automatic send_word(input tone_word_type w);
      req_valid <= 1'b1;
      req_kind <= w.kind;
      req_frequency <= w.freq;
      req_duty_hundredths <= w.hund;
      req_duration <= w.dur;
      req_note_slot <= w.slot;
      req_note_count <= w.count;
      req_direction_up <= w.up;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause_sender(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_results.size() != 0)
         @(posedge clock);
      repeat (RESULT_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_resolution(input logic [4:0] v);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'(4 * CSR_RESOLUTION);
      csr_pwdata <= CSR_DATA_W'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.res_bits = v;
      // read back
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(v))
         sb.report($sformatf("resolution_bits read %0d want %0d", csr_prdata, v));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin : stimulus
      tone_word_type directed [$];
      tone_word_type w;
      logic [4:0]    res_plan [6];
      int            per_phase;
      int            sent;
      int            burst;
      bit            held;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_TICK;
      req_frequency = '0;
      req_duty_hundredths = '0;
      req_duration = '0;
      req_note_slot = '0;
      req_note_count = '0;
      req_direction_up = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      sb = new();
      held = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      directed.push_back(make_word(KIND_LOAD_NOTE, 16'hFFFF, 0, 0, 4'd0, 0, 0));
      directed.push_back(make_word(KIND_LOAD_NOTE, 16'h0000, 0, 0, 4'd1, 0, 0));
      directed.push_back(make_word(KIND_LOAD_NOTE, 16'd1234, 0, 0, 4'd15, 0, 0));
      directed.push_back(make_word(KIND_TICK, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_word(KIND_DUTY_TONE, 16'hFFFF, DUTY_FULL, 0, 0, 0, 0));
      directed.push_back(make_word(KIND_TICK, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_word(KIND_DUTY_TONE, 16'd440, 14'h3FFF, 2, 0, 0, 0));
      directed.push_back(make_word(KIND_FIXED_TONE, 16'd880, 0, 5, 0, 0, 0));
      directed.push_back(make_word(KIND_SCALE, 0, 0, 1, 0, 5'd2, 1));
      directed.push_back(make_word(KIND_TICK, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_word(KIND_TICK, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_word(KIND_FIXED_TONE, 16'd1000, 0, '1, 0, 0, 0));
      directed.push_back(make_word(KIND_TICK, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_word(KIND_STOP, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_word(KIND_SCALE, 0, 0, 1, 0, 5'd0, 1));
      directed.push_back(make_word(KIND_SCALE, 0, 0, 0, 0, 5'd2, 1));
      directed.push_back(make_word(KIND_TICK, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_word(KIND_TICK, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_word(KIND_SCALE, 0, 0, 1, 0, 5'd2, 0));
      repeat (4) directed.push_back(make_word(KIND_TICK, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_word(KIND_UNUSED_LO, 16'd77, 0, 3, 0, 0, 0));
      directed.push_back(make_word(KIND_UNUSED_HI, 16'd99, 0, 3, 0, 0, 0));
      foreach (directed[i]) begin
         send_word(directed[i]);
         pause_sender($urandom_range(0, 2));
      end
      drain();

      res_plan = '{5'd1, RES_MAX, 5'd0, 5'd31, 5'd13, 5'($urandom_range(2, 19))};
      per_phase = RANDOM_WORDS / 6;
      foreach (res_plan[p]) begin
         write_resolution(res_plan[p]);
         sent = 0;
         while (sent < per_phase) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
               w = random_word();
               send_word(w);
               if (w.kind <= KIND_STOP)
                  sent++;
               if (p == 0 && sent >= 80 && !held) begin
                  held = 1'b1;
                  hold_cycles = HOLD_OFF_CYCLES;
               end
            end
            if ($urandom_range(0, 3) != 0)
               pause_sender($urandom_range(1, 6));
         end
         drain();
      end

      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin : watchdog
      #(12 * LIMIT_CYCLES);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
